### rtl/core/crvs_pkg.sv
package crvs_pkg;

	localparam int ELEM_W    = 32;
	localparam int DIM_W     = 5;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_CAND_RD  = 8'b0000_0010,
		ST_CAND_CHK = 8'b0000_0100,
		ST_ROW_RD   = 8'b0000_1000,
		ST_ROW_CMP  = 8'b0001_0000,
		ST_SEL_RD   = 8'b0010_0000,
		ST_SEL_CMP  = 8'b0100_0000,
		ST_SEL_END  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic eq;
		logic lt;
		logic gt;
	} cmp_res_t;

endpackage

### rtl/core/common_row_values_sorted_scan.sv
// Loads a num_rows x num_cols matrix of signed 32-bit elements, row-major, one
// element per cycle, then emits every distinct value present in all rows in
// descending signed order, the final one flagged by last_of_run; if nothing is
// common, a single transaction with none_found set is emitted. After the last
// element the block holds in_ready low while a sequencer drives the single read
// port of the matrix memory (registered read) and one shared compare unit.
// Membership checks each row-0 candidate against rows 1..R-1, scanning at most
// (R-1)*C elements; selection then makes (N+1) passes over row 0 for N results,
// each pass able to wait on an output stall before it ends. Writes to the row or
// column count clear a partial load; no clearing pass is needed after reset.
module common_row_values_sorted_scan #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [crvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crvs_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [crvs_pkg::ELEM_W-1:0]    element,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [crvs_pkg::ELEM_W-1:0]    common_value,
	output logic                           none_found,
	output logic                           last_of_run
);
	import crvs_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [DIM_W-1:0]  num_rows_q;
	logic [DIM_W-1:0]  num_cols_q;
	logic [RW-1:0]     last_row;
	logic [CW-1:0]     last_col;
	logic              cfg_clr;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [ELEM_W-1:0] mem_wdata;
	logic [ELEM_W-1:0] mem_rdata;
	logic [ELEM_W-1:0] chk_prev_q;
	logic              chk_open_q;

	assign cfg_ready = 1'b1;
	assign cfg_clr   = cfg_valid && ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_RESET;
			num_cols_q <= DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				REG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero reads as one, oversize saturates
	always_comb begin
		if (num_rows_q == '0) begin
			last_row = '0;
		end else if ({1'b0, num_rows_q} > (DIM_W + 1)'(MAX_ROWS)) begin
			last_row = RW'(MAX_ROWS - 1);
		end else begin
			last_row = RW'(num_rows_q - DIM_W'(1));
		end
		if (num_cols_q == '0) begin
			last_col = '0;
		end else if ({1'b0, num_cols_q} > (DIM_W + 1)'(MAX_COLS)) begin
			last_col = CW'(MAX_COLS - 1);
		end else begin
			last_col = CW'(num_cols_q - DIM_W'(1));
		end
	end

	crvs_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	crvs_ctrl #(
		.MAX_COLS (MAX_COLS),
		.RW       (RW),
		.CW       (CW),
		.AW       (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.last_row     (last_row),
		.last_col     (last_col),
		.cfg_clr      (cfg_clr),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element      (element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.common_value (common_value),
		.none_found   (none_found),
		.last_of_run  (last_of_run),
		.mem_we       (mem_we),
		.mem_re       (mem_re),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata)
	);

	// last value delivered in the current run, for the ordering check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_open_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			chk_open_q <= !last_of_run;
			chk_prev_q <= common_value;
		end
	end

	a_desc_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chk_open_q |-> $signed(common_value) < $signed(chk_prev_q))
		else $error("results not strictly descending");

	a_none_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && none_found |-> last_of_run && (common_value == '0))
		else $error("none transaction malformed");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("memory read during load");

endmodule

### rtl/core/crvs_cmp.sv
module crvs_cmp (
	input  logic [crvs_pkg::ELEM_W-1:0] data,
	input  logic [crvs_pkg::ELEM_W-1:0] ref_a,
	input  logic [crvs_pkg::ELEM_W-1:0] ref_b,
	output crvs_pkg::cmp_res_t          res
);
	import crvs_pkg::*;

	// signed compare: eq/lt against ref_a, gt against ref_b
	always_comb begin
		res.eq = (data == ref_a);
		res.lt = ($signed(data) < $signed(ref_a));
		res.gt = ($signed(data) > $signed(ref_b));
	end

endmodule

### rtl/core/crvs_mem.sv
module crvs_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [crvs_pkg::ELEM_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [crvs_pkg::ELEM_W-1:0] rdata
);
	import crvs_pkg::*;

	logic [ELEM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/crvs_ctrl.sv
module crvs_ctrl #(
	parameter int MAX_COLS = 16,
	parameter int RW       = 4,
	parameter int CW       = 4,
	parameter int AW       = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [RW-1:0]               last_row,
	input  logic [CW-1:0]               last_col,
	input  logic                        cfg_clr,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [crvs_pkg::ELEM_W-1:0] element,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [crvs_pkg::ELEM_W-1:0] common_value,
	output logic                        none_found,
	output logic                        last_of_run,
	output logic                        mem_we,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_addr,
	output logic [crvs_pkg::ELEM_W-1:0] mem_wdata,
	input  logic [crvs_pkg::ELEM_W-1:0] mem_rdata
);
	import crvs_pkg::*;

	state_t            state_q;
	logic [RW-1:0]     r_q;
	logic [CW-1:0]     c_q;
	logic [CW-1:0]     j_q;
	logic [AW-1:0]     rbase_q;
	logic [MAX_COLS-1:0] common_q;
	logic [ELEM_W-1:0] cand_q;
	logic [ELEM_W-1:0] best_q;
	logic [ELEM_W-1:0] bound_q;
	logic [ELEM_W-1:0] pend_q;
	logic              found_q;
	logic              have_bound_q;
	logic              pend_valid_q;
	logic              out_valid_q;
	logic [ELEM_W-1:0] out_value_q;
	logic              out_none_q;
	logic              out_last_q;
	logic [ELEM_W-1:0] ref_a;
	cmp_res_t          cmp;
	logic              push_need;
	logic              out_free;
	logic              sel_hit;

	assign ref_a = (state_q == ST_ROW_CMP) ? cand_q : bound_q;

	crvs_cmp u_cmp (
		.data  (mem_rdata),
		.ref_a (ref_a),
		.ref_b (best_q),
		.res   (cmp)
	);

	assign in_ready     = (state_q == ST_IDLE);
	assign mem_we       = in_valid && in_ready;
	assign mem_wdata    = element;
	assign mem_re       = (state_q == ST_CAND_RD) || (state_q == ST_ROW_RD) ||
	                      (state_q == ST_SEL_RD);
	assign mem_addr     = ((state_q == ST_CAND_RD) || (state_q == ST_SEL_RD)) ?
	                      AW'(j_q) : (rbase_q + AW'(c_q));
	assign out_valid    = out_valid_q;
	assign common_value = out_value_q;
	assign none_found   = out_none_q;
	assign last_of_run  = out_last_q;

	// previous best is held back until the next pass shows whether it was last
	assign push_need = !found_q || pend_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign sel_hit   = common_q[j_q] && (!have_bound_q || cmp.lt) && (!found_q || cmp.gt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			r_q          <= '0;
			c_q          <= '0;
			j_q          <= '0;
			rbase_q      <= '0;
			common_q     <= '0;
			found_q      <= 1'b0;
			have_bound_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_SEL_END) && push_need && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_clr) begin
						r_q     <= '0;
						c_q     <= '0;
						rbase_q <= '0;
					end else if (in_valid) begin
						if ((r_q == last_row) && (c_q == last_col)) begin
							j_q     <= '0;
							state_q <= ST_CAND_RD;
						end else if (c_q == last_col) begin
							c_q     <= '0;
							r_q     <= r_q + RW'(1);
							rbase_q <= rbase_q + AW'(MAX_COLS);
						end else begin
							c_q <= c_q + CW'(1);
						end
					end
				end
				ST_CAND_RD: begin
					state_q <= ST_CAND_CHK;
				end
				ST_CAND_CHK: begin
					cand_q <= mem_rdata;
					if (last_row == '0) begin
						common_q[j_q] <= 1'b1;
						if (j_q == last_col) begin
							j_q          <= '0;
							found_q      <= 1'b0;
							have_bound_q <= 1'b0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_SEL_RD;
						end else begin
							j_q     <= j_q + CW'(1);
							state_q <= ST_CAND_RD;
						end
					end else begin
						r_q     <= RW'(1);
						rbase_q <= AW'(MAX_COLS);
						c_q     <= '0;
						state_q <= ST_ROW_RD;
					end
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW_CMP;
				end
				ST_ROW_CMP: begin
					if (cmp.eq && (r_q != last_row)) begin
						r_q     <= r_q + RW'(1);
						rbase_q <= rbase_q + AW'(MAX_COLS);
						c_q     <= '0;
						state_q <= ST_ROW_RD;
					end else if (!cmp.eq && (c_q != last_col)) begin
						c_q     <= c_q + CW'(1);
						state_q <= ST_ROW_RD;
					end else begin
						// candidate settled: hit in last row, or row exhausted
						common_q[j_q] <= cmp.eq;
						if (j_q == last_col) begin
							j_q          <= '0;
							found_q      <= 1'b0;
							have_bound_q <= 1'b0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_SEL_RD;
						end else begin
							j_q     <= j_q + CW'(1);
							state_q <= ST_CAND_RD;
						end
					end
				end
				ST_SEL_RD: begin
					state_q <= ST_SEL_CMP;
				end
				ST_SEL_CMP: begin
					if (sel_hit) begin
						found_q <= 1'b1;
						best_q  <= mem_rdata;
					end
					if (j_q == last_col) begin
						state_q <= ST_SEL_END;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= ST_SEL_RD;
					end
				end
				ST_SEL_END: begin
					if (!push_need || out_free) begin
						if (push_need) begin
							out_value_q <= pend_valid_q ? pend_q : '0;
							out_none_q  <= !pend_valid_q;
							out_last_q  <= !found_q;
						end
						if (found_q) begin
							pend_q       <= best_q;
							pend_valid_q <= 1'b1;
							bound_q      <= best_q;
							have_bound_q <= 1'b1;
							found_q      <= 1'b0;
							j_q          <= '0;
							state_q      <= ST_SEL_RD;
						end else begin
							pend_valid_q <= 1'b0;
							r_q          <= '0;
							c_q          <= '0;
							rbase_q      <= '0;
							state_q      <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### verif/tb_common_row_values_sorted_scan.sv
`timescale 1ns / 100ps

module tb_common_row_values_sorted_scan;
	import crvs_pkg::*;

	localparam int MAX_ROWS      = 16;
	localparam int MAX_COLS      = 16;
	localparam int SETTLE_CYCLES = 32;
	localparam int DRAIN_CYCLES  = 64;

	localparam logic [ELEM_W-1:0]    WORD_MIN     = 32'h8000_0000;
	localparam logic [ELEM_W-1:0]    WORD_MAX     = 32'h7FFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(15);

	typedef struct packed {
		logic [ELEM_W-1:0] value;
		logic              is_none;
		logic              is_last;
	} scan_result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [DIM_W-1:0]     cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [ELEM_W-1:0]    element     = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [ELEM_W-1:0]    common_value;
	logic                 none_found;
	logic                 last_of_run;

	// expected common values, oldest first
	scan_result_t      pending_results[$];
	logic [ELEM_W-1:0] shadow_matrix [MAX_ROWS][MAX_COLS];
	logic [DIM_W-1:0]  shadow_rows = DIM_RESET;
	logic [DIM_W-1:0]  shadow_cols = DIM_RESET;
	int                loaded_count = 0;

	int idle_pct     = 0;
	int stall_pct    = 0;
	int hold_request = 0;
	int hold_left    = 0;
	int items_sent   = 0;
	int error_count  = 0;

	common_row_values_sorted_scan dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element      (element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.common_value (common_value),
		.none_found   (none_found),
		.last_of_run  (last_of_run)
	);

	always #5 clk = ~clk;

	function automatic int clamp_dim(logic [DIM_W-1:0] v, int limit);
		if (v == 0)
			return 1;
		if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		if (idx == REG_NUM_ROWS) begin
			shadow_rows  = data;
			loaded_count = 0;
		end else if (idx == REG_NUM_COLS) begin
			shadow_cols  = data;
			loaded_count = 0;
		end
	endfunction

	// store one element; on the last one of the matrix, queue the common values
	function automatic void absorb_element(logic [ELEM_W-1:0] v);
		int                       rows;
		int                       cols;
		int                       pos;
		bit                       in_row;
		bit                       in_all;
		logic signed [ELEM_W-1:0] cand;
		logic signed [ELEM_W-1:0] common_q[$];
		scan_result_t             res;
		rows = clamp_dim(shadow_rows, MAX_ROWS);
		cols = clamp_dim(shadow_cols, MAX_COLS);
		if (loaded_count >= rows * cols)
			loaded_count = 0;
		shadow_matrix[loaded_count / cols][loaded_count % cols] = v;
		loaded_count++;
		if (loaded_count < rows * cols)
			return;
		loaded_count = 0;
		for (int c = 0; c < cols; c++) begin
			cand   = shadow_matrix[0][c];
			in_all = 1'b1;
			for (int r = 1; r < rows; r++) begin
				in_row = 1'b0;
				for (int k = 0; k < cols; k++)
					if (shadow_matrix[r][k] == cand)
						in_row = 1'b1;
				if (!in_row)
					in_all = 1'b0;
			end
			if (in_all) begin
				pos = 0;
				while (pos < common_q.size() && common_q[pos] > cand)
					pos++;
				if (pos == common_q.size() || common_q[pos] != cand)
					common_q.insert(pos, cand);
			end
		end
		if (common_q.size() == 0) begin
			res = '{value: '0, is_none: 1'b1, is_last: 1'b1};
			pending_results.insert(pending_results.size(), res);
		end else begin
			foreach (common_q[i]) begin
				res = '{value: common_q[i], is_none: 1'b0,
					is_last: (i == common_q.size() - 1)};
				pending_results.insert(pending_results.size(), res);
			end
		end
	endfunction

	function automatic logic [ELEM_W-1:0] rand_word();
		case ($urandom_range(15))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_element(logic [ELEM_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		element  <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		absorb_element(v);
		items_sent++;
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for all outstanding results, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
		settle();
		write_register(REG_NUM_ROWS, rows);
		write_register(REG_NUM_COLS, cols);
	endtask

	// zero row count acts as one row; duplicates in the row collapse
	task automatic test_single_row();
		set_dims(DIM_W'(0), DIM_W'(4));
		send_element(WORD_MAX);
		send_element(WORD_MIN);
		send_element(WORD_MAX);
		send_element('1);
	endtask

	// oversize row count clamps to 16, zero column count acts as one
	task automatic test_dim_saturation();
		set_dims(DIM_W'(31), DIM_W'(0));
		repeat (MAX_ROWS)
			send_element(WORD_MIN);
	endtask

	task automatic test_no_common();
		set_dims(DIM_W'(2), DIM_W'(2));
		send_element('0);
		send_element('1);
		send_element(WORD_MIN);
		send_element(WORD_MAX);
	endtask

	// write to an unmapped index must not disturb a partial load
	task automatic test_unmapped_index();
		set_dims(DIM_W'(2), DIM_W'(2));
		send_element(32'd5);
		send_element(32'd6);
		settle();
		write_register(REG_UNMAPPED, 5'h1F);
		send_element(32'd6);
		send_element(32'd5);
	endtask

	// register write mid-load throws the partial matrix away
	task automatic test_load_abort();
		set_dims(DIM_W'(2), DIM_W'(2));
		send_element(32'd9);
		settle();
		write_register(REG_NUM_COLS, DIM_W'(2));
		send_element(32'd7);
		send_element(32'd8);
		send_element(32'd8);
		send_element(32'd7);
	endtask

	// long output stall while two full-result matrices queue up behind it
	task automatic test_output_backpressure();
		logic [ELEM_W-1:0] first_row [MAX_COLS];
		idle_pct  = 0;
		stall_pct = 0;
		set_dims(DIM_W'(2), DIM_W'(MAX_COLS));
		hold_request = 400;
		repeat (2) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				first_row[c] = {4'(c), 28'($urandom())};
				send_element(first_row[c]);
			end
			for (int c = MAX_COLS - 1; c >= 0; c--)
				send_element(first_row[c]);
		end
	endtask

	task automatic test_random_traffic(int n_items, int send_idle, int recv_stall);
		int                target;
		int                rows;
		int                cols;
		int                count;
		int                pick;
		bit                well_formed;
		bit                must_config;
		logic [DIM_W-1:0]  rows_code;
		logic [ELEM_W-1:0] v;
		logic [ELEM_W-1:0] pool [MAX_COLS];
		logic [ELEM_W-1:0] first_row [MAX_COLS];
		idle_pct    = send_idle;
		stall_pct   = recv_stall;
		target      = items_sent + n_items;
		must_config = 1'b1;
		rows        = 1;
		cols        = 1;
		while (items_sent < target) begin
			if (must_config || $urandom_range(1)) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					rows = MAX_ROWS;
					cols = $urandom_range(1, 2);
				end else if (pick < 16) begin
					rows = $urandom_range(1, 2);
					cols = MAX_COLS;
				end else begin
					rows = $urandom_range(1, 4);
					cols = $urandom_range(1, 6);
				end
				rows_code = DIM_W'(rows);
				if (rows == 1 && $urandom_range(1))
					rows_code = '0;
				if (rows == MAX_ROWS && $urandom_range(1))
					rows_code = DIM_W'($urandom_range(MAX_ROWS + 1, 31));
				set_dims(rows_code, DIM_W'(cols));
				if ($urandom_range(4) == 0)
					write_register(CFG_IDX_W'($urandom_range(2, 15)), DIM_W'($urandom()));
			end
			count       = rows * cols;
			must_config = 1'b0;
			if ($urandom_range(9) == 0 && count > 1) begin
				count       = $urandom_range(1, count - 1);
				must_config = 1'b1;
			end
			well_formed = ($urandom_range(3) != 0);
			for (int c = 0; c < MAX_COLS; c++)
				pool[c] = rand_word();
			for (int i = 0; i < count; i++) begin
				if (!well_formed)
					v = rand_word();
				else if (i < cols) begin
					v            = pool[$urandom_range(cols - 1)];
					first_row[i] = v;
				end else if ($urandom_range(9) != 0)
					v = first_row[$urandom_range(cols - 1)];
				else
					v = rand_word();
				send_element(v);
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transaction: common_value %0d none_found %0b last_of_run %0b",
					$signed(common_value), none_found, last_of_run);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (common_value !== want.value) begin
					$error("common_value: expected %0d, got %0d",
						$signed(want.value), $signed(common_value));
					error_count++;
				end
				if (none_found !== want.is_none) begin
					$error("none_found: expected %0b, got %0b", want.is_none, none_found);
					error_count++;
				end
				if (last_of_run !== want.is_last) begin
					$error("last_of_run: expected %0b, got %0b", want.is_last, last_of_run);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_row();
		test_dim_saturation();
		test_no_common();
		test_unmapped_index();
		test_load_abort();
		test_output_backpressure();
		test_random_traffic(85, 0, 0);
		test_random_traffic(85, 63, 0);
		test_random_traffic(85, 0, 63);
		test_random_traffic(85, 21, 21);
		settle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("tb_common_row_values_sorted_scan: clean");
		else
			$display("tb_common_row_values_sorted_scan: errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_common_row_values_sorted_scan: errors");
		$finish;
	end

endmodule

### filelist.f
rtl/core/crvs_pkg.sv
rtl/core/crvs_cmp.sv
rtl/core/crvs_mem.sv
rtl/core/crvs_ctrl.sv
rtl/core/common_row_values_sorted_scan.sv
verif/tb_common_row_values_sorted_scan.sv
